FILE: hdl/cmr_pkg.sv
// cmr_pkg: shared types and codes for the checked multiply-divide core
// no dependencies; used by the interfaces, the core, its divider step and the checker
package cmr_pkg;

    // fixed field widths of the item channels
    localparam int FIELD_W = 64;
    localparam int MODE_W  = 2;
    localparam int ERR_W   = 2;

    // result status codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    // rounding modes
    typedef enum logic [MODE_W-1:0] {
        RND_ZERO  = 2'd0,
        RND_FLOOR = 2'd1,
        RND_CEIL  = 2'd2,
        RND_HALF  = 2'd3
    } rnd_t;

    // control that travels with every item down the pipeline
    typedef struct packed {
        logic neg;
        rnd_t mode;
        err_t err;
    } ctl_t;

endpackage

FILE: hdl/cmr_if.sv
// cmr_in_if / cmr_out_if: valid-ready item channels of the multiply-divide core
// depends on cmr_pkg for field widths
interface cmr_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [cmr_pkg::FIELD_W-1:0] multiplicand;
    logic signed [cmr_pkg::FIELD_W-1:0] multiplier;
    logic signed [cmr_pkg::FIELD_W-1:0] divisor;
    logic [cmr_pkg::MODE_W-1:0]         rounding_mode;

    modport source (output valid, multiplicand, multiplier, divisor, rounding_mode,
                    input ready);
    modport sink   (input valid, multiplicand, multiplier, divisor, rounding_mode,
                    output ready);
endinterface

interface cmr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [cmr_pkg::FIELD_W-1:0] quotient;
    logic [cmr_pkg::ERR_W-1:0]          error_code;

    modport source (output valid, quotient, error_code, input ready);
    modport sink   (input valid, quotient, error_code, output ready);
endinterface

FILE: hdl/checked_muldiv_rounding_core.sv
// checked_muldiv_rounding_core: pipelined a*b/d with rounding and error checks
// depends on cmr_pkg, cmr_if (channels) and cmr_div_step (divider stage)

// One item enters per clock and one result leaves per clock when the output is
// taken. Stages: operand magnitudes, four partial products, product sum,
// quotient-width check, one restoring-division stage per quotient bit,
// rounding, and the range check in the output register. Only the low
// DATA_WIDTH bits of each operand are used, sign-extended; the quotient is
// returned in the low DATA_WIDTH bits. The whole pipeline holds when the
// output item is not taken, so in_ch.ready is high whenever the output
// register is empty or being read.
module checked_muldiv_rounding_core #(
    parameter int DATA_WIDTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    cmr_in_if.sink        in_ch,
    cmr_out_if.source     out_ch
);
    import cmr_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int LO_W = W / 2;
    localparam int HI_W = W - LO_W;
    localparam int P2   = 2 * W;

    logic adv;

    // stage 1: magnitudes
    logic         v1_reg;
    logic [W-1:0] a_reg, b_reg, d1_reg;
    ctl_t         ctl1_reg;
    // stage 2: partial products
    logic                 v2_reg;
    logic [2*LO_W-1:0]    pp_ll_reg;
    logic [W-1:0]         pp_lh_reg, pp_hl_reg;
    logic [2*HI_W-1:0]    pp_hh_reg;
    logic [W-1:0]         d2_reg;
    ctl_t                 ctl2_reg;
    // stage 3: product
    logic          v3_reg;
    logic [P2-1:0] prod_reg;
    logic [W-1:0]  d3_reg;
    ctl_t          ctl3_reg;
    // stage 4: quotient width check, divider inputs
    logic         v4_reg;
    logic [W-1:0] rem4_reg, dq4_reg, d4_reg;
    ctl_t         ctl4_reg;
    // rounding stage
    logic         vr_reg;
    logic [W-1:0] qr_reg;
    ctl_t         ctlr_reg;
    // output register
    logic         vo_reg;
    logic [W-1:0] qo_reg;
    err_t         eo_reg;

    // divider chain
    logic         dv_s  [0:W];
    logic [W-1:0] rem_s [0:W];
    logic [W-1:0] dq_s  [0:W];
    logic [W-1:0] d_s   [0:W];
    ctl_t         ctl_s [0:W];

    assign adv         = !vo_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // operand magnitudes and result sign
    logic [W-1:0] a_in, b_in, d_in;
    logic [W-1:0] a_mag, b_mag, d_mag;
    ctl_t         ctl1_next;
    always_comb
    begin
        a_in  = in_ch.multiplicand[W-1:0];
        b_in  = in_ch.multiplier[W-1:0];
        d_in  = in_ch.divisor[W-1:0];
        a_mag = a_in[W-1] ? -a_in : a_in;
        b_mag = b_in[W-1] ? -b_in : b_in;
        d_mag = d_in[W-1] ? -d_in : d_in;
        ctl1_next.neg  = a_in[W-1] ^ b_in[W-1] ^ d_in[W-1];
        ctl1_next.mode = rnd_t'(in_ch.rounding_mode);
        ctl1_next.err  = (d_in == '0) ? ERR_DIV_ZERO : ERR_NONE;
    end

    // partial products of the half words
    logic [2*LO_W-1:0] pp_ll_next;
    logic [W-1:0]      pp_lh_next, pp_hl_next;
    logic [2*HI_W-1:0] pp_hh_next;
    always_comb
    begin
        pp_ll_next = a_reg[LO_W-1:0] * b_reg[LO_W-1:0];
        pp_lh_next = a_reg[LO_W-1:0] * b_reg[W-1:LO_W];
        pp_hl_next = a_reg[W-1:LO_W] * b_reg[LO_W-1:0];
        pp_hh_next = a_reg[W-1:LO_W] * b_reg[W-1:LO_W];
    end

    // full product
    logic [P2-1:0] prod_next;
    always_comb
    begin
        prod_next = (P2'(pp_hh_reg) << (2 * LO_W)) + (P2'(pp_hl_reg) << LO_W)
                  + (P2'(pp_lh_reg) << LO_W) + P2'(pp_ll_reg);
    end

    // the quotient fits W bits only if the upper product half is below the divisor
    ctl_t ctl4_next;
    always_comb
    begin
        ctl4_next = ctl3_reg;
        if (ctl3_reg.err == ERR_NONE && prod_reg[P2-1:W] >= d3_reg)
            ctl4_next.err = ERR_OVERFLOW;
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload of the front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= a_mag;
            b_reg     <= b_mag;
            d1_reg    <= d_mag;
            ctl1_reg  <= ctl1_next;
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
            d2_reg    <= d1_reg;
            ctl2_reg  <= ctl1_reg;
            prod_reg  <= prod_next;
            d3_reg    <= d2_reg;
            ctl3_reg  <= ctl2_reg;
            rem4_reg  <= prod_reg[P2-1:W];
            dq4_reg   <= prod_reg[W-1:0];
            d4_reg    <= d3_reg;
            ctl4_reg  <= ctl4_next;
        end
    end

    // restoring divider, one quotient bit per stage
    assign dv_s[0]  = v4_reg;
    assign rem_s[0] = rem4_reg;
    assign dq_s[0]  = dq4_reg;
    assign d_s[0]   = d4_reg;
    assign ctl_s[0] = ctl4_reg;

    for (genvar g = 0; g < W; g++)
    begin : g_div
        cmr_div_step #(.W(W)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (dv_s[g]),
            .rem_in    (rem_s[g]),
            .dq_in     (dq_s[g]),
            .d_in      (d_s[g]),
            .ctl_in    (ctl_s[g]),
            .valid_out (dv_s[g+1]),
            .rem_out   (rem_s[g+1]),
            .dq_out    (dq_s[g+1]),
            .d_out     (d_s[g+1]),
            .ctl_out   (ctl_s[g+1])
        );
    end

    // rounding decision and increment
    logic [W-1:0] rem_f, q_f, d_f;
    logic         rem_nz, up;
    logic [W:0]   rem2;
    logic [W-1:0] qr_next;
    ctl_t         ctlr_next;
    always_comb
    begin
        rem_f  = rem_s[W];
        q_f    = dq_s[W];
        d_f    = d_s[W];
        rem_nz = rem_f != '0;
        rem2   = {rem_f, 1'b0};
        case (ctl_s[W].mode)
            RND_FLOOR: up = rem_nz && ctl_s[W].neg;
            RND_CEIL:  up = rem_nz && !ctl_s[W].neg;
            RND_HALF:  up = rem_nz && (rem2 >= {1'b0, d_f});
            default:   up = 1'b0;
        endcase
        ctlr_next = ctl_s[W];
        if (ctl_s[W].err == ERR_NONE && up && q_f == '1)
            ctlr_next.err = ERR_OVERFLOW;
        qr_next = q_f + W'(up);
    end

    // signed range check and final sign
    logic [W-1:0] qo_next;
    err_t         eo_next;
    logic         out_of_range;
    always_comb
    begin
        out_of_range = qr_reg[W-1] && (!ctlr_reg.neg || qr_reg[W-2:0] != '0);
        eo_next      = ctlr_reg.err;
        if (eo_next == ERR_NONE && out_of_range)
            eo_next = ERR_OVERFLOW;
        if (eo_next != ERR_NONE)
            qo_next = '0;
        else
            qo_next = ctlr_reg.neg ? -qr_reg : qr_reg;
    end

    // valid bits of the back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vr_reg <= dv_s[W];
            vo_reg <= vr_reg;
        end
    end

    // payload of the back stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qr_reg   <= qr_next;
            ctlr_reg <= ctlr_next;
            qo_reg   <= qo_next;
            eo_reg   <= eo_next;
        end
    end

    assign out_ch.valid      = vo_reg;
    assign out_ch.quotient   = FIELD_W'(qo_reg);
    assign out_ch.error_code = eo_reg;

endmodule

FILE: hdl/cmr_div_step.sv
// cmr_div_step: one registered restoring-division step
// depends on cmr_pkg for the control struct
module cmr_div_step #(
    parameter int W = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [W-1:0]         rem_in,
    input  logic [W-1:0]         dq_in,
    input  logic [W-1:0]         d_in,
    input  cmr_pkg::ctl_t        ctl_in,
    output logic                 valid_out,
    output logic [W-1:0]         rem_out,
    output logic [W-1:0]         dq_out,
    output logic [W-1:0]         d_out,
    output cmr_pkg::ctl_t        ctl_out
);
    import cmr_pkg::*;

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] rem_next;
    logic [W-1:0] dq_next;

    // shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_in, dq_in[W-1]};
        diff     = trial - {1'b0, d_in};
        ge       = trial >= {1'b0, d_in};
        rem_next = ge ? diff[W-1:0] : trial[W-1:0];
        dq_next  = {dq_in[W-2:0], ge};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out <= 1'b0;
        else if (en)
            valid_out <= valid_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= rem_next;
            dq_out  <= dq_next;
            d_out   <= d_in;
            ctl_out <= ctl_in;
        end
    end

endmodule

FILE: hdl/cmr_checker.sv
// cmr_checker: port-level assertions for the multiply-divide core
// depends on cmr_pkg; bound to checked_muldiv_rounding_core below
module cmr_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [cmr_pkg::FIELD_W-1:0]  quotient,
    input logic [cmr_pkg::ERR_W-1:0]    error_code
);
    import cmr_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(error_code))
        else $error("result item changed while stalled");

    // input is taken exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output space");

    // an error result carries a zero quotient
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> quotient == '0)
        else $error("error result with nonzero quotient");

    // only defined status codes
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_code == ERR_NONE || error_code == ERR_DIV_ZERO
                   || error_code == ERR_OVERFLOW)
        else $error("undefined status code");

endmodule

bind checked_muldiv_rounding_core cmr_checker u_cmr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .quotient   (out_ch.quotient),
    .error_code (out_ch.error_code)
);
